FILE: hw/rtl/psrt_pkg.sv
package psrt_pkg;

  // Table depth default and the width of the result's index field
  localparam int unsigned TableEntriesDef = 12;
  localparam int unsigned EntryIndexW     = 4;

  // Interval after reset: one day in milliseconds
  localparam logic [31:0] DefaultIntervalMs = 32'd86400000;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  // Operand select for the shared compare unit
  typedef struct packed {
    logic        sub_en;   // compare (a - b) instead of a
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] limit;
  } alu_req_t;

endpackage

FILE: hw/rtl/psrt_if.sv
// Request word: requester number and current uptime
interface psrt_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] requester;
  logic [31:0] now_ms;

  modport source (output valid, output requester, output now_ms, input ready);
  modport sink   (input valid, input requester, input now_ms, output ready);
endinterface

// Result word
interface psrt_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               reply_due;
  logic                               was_known;
  logic [psrt_pkg::EntryIndexW-1:0]   entry_index;
  logic                               evicted;

  modport source (output valid, output reply_due, output was_known,
                  output entry_index, output evicted, input ready);
  modport sink   (input valid, input reply_due, input was_known,
                  input entry_index, input evicted, output ready);
endinterface

// Configuration write: reply interval
interface psrt_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] reply_interval_ms;

  modport source (output valid, output reply_interval_ms, input ready);
  modport sink   (input valid, input reply_interval_ms, output ready);
endinterface

FILE: hw/rtl/per_source_reply_throttle.sv
// Per-requester reply throttle. Each request word (requester, now_ms) is looked
// up in a table of TableEntries entries holding requester number and the time it
// was last heard. The lookup walks the table one entry per cycle and stops at
// the first entry that holds the requester or is unused; with a full table the
// entry with the smallest stored time (plain unsigned, lowest index on ties) is
// replaced. A reply is due for an unknown requester or once (now_ms - stored
// time) mod 2^32 reaches reply_interval_ms. The chosen entry is always restamped.
// A request passes through an accept step, a scan of 1 to TableEntries entries
// and a write-back step; the scan length is set by the entry-by-entry walk through
// the single shared comparator. The write-back waits while a previous result word
// is still held. The request side is ready only while the sequencer is idle; the
// result sits in an output register, so a new request is taken while a result
// waits. The interval register resets to one day and may be written at any idle
// time.
module per_source_reply_throttle #(
  parameter int unsigned TableEntries = psrt_pkg::TableEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  psrt_req_if.sink           req_i,
  psrt_rsp_if.source         rsp_o,
  psrt_cfg_if.sink           cfg_i
);
  import psrt_pkg::*;

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  // Table storage
  logic [TableEntries-1:0] valid_q, valid_d;
  logic [31:0]             req_mem_q  [TableEntries];
  logic [31:0]             time_mem_q [TableEntries];

  // Sequencer and working registers
  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] least_idx_q, least_idx_d;
  logic [31:0]     least_time_q, least_time_d;
  logic [IdxW-1:0] pick_q, pick_d;
  logic [31:0]     tsel_q, tsel_d;
  logic            known_q, known_d;
  logic            evict_q, evict_d;
  logic [31:0]     who_q, now_q;
  logic [31:0]     interval_q;

  // Output register
  logic                   out_valid_q, out_valid_d;
  logic                   out_due_q, out_known_q, out_evict_q;
  logic [EntryIndexW-1:0] out_index_q;

  logic            in_fire, out_fire, wr_fire;
  logic            rd_valid, hit, lt, take_least, due;
  logic [31:0]     rd_req_q, rd_time_q;
  logic [IdxW+EntryIndexW-1:0] pick_ext;
  alu_req_t        alu_req;

  assign in_fire  = req_i.valid && req_i.ready;
  assign out_fire = out_valid_q && rsp_o.ready;
  assign wr_fire  = (state_q == ST_WRITE) && (!out_valid_q || rsp_o.ready);

  // Entry at the scan index; table data is registered from idx_d so it lines up with idx_q
  assign rd_valid = valid_q[idx_q];
  assign hit      = !rd_valid || (rd_req_q == who_q);

  // Shared comparator: oldest-entry search while scanning, elapsed check at write
  always_comb begin
    alu_req = '0;
    if (state_q == ST_WRITE) begin
      alu_req.sub_en = 1'b1;
      alu_req.a      = now_q;
      alu_req.b      = tsel_q;
      alu_req.limit  = interval_q;
    end else begin
      alu_req.sub_en = 1'b0;
      alu_req.a      = rd_time_q;
      alu_req.limit  = least_time_q;
    end
  end

  psrt_alu u_alu (
    .req_i (alu_req),
    .lt_o  (lt)
  );

  assign take_least = (idx_q == '0) || lt;
  assign due        = !known_q || !lt;
  assign pick_ext   = {{EntryIndexW{1'b0}}, pick_q};

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    least_idx_d  = least_idx_q;
    least_time_d = least_time_q;
    pick_d       = pick_q;
    tsel_d       = tsel_q;
    known_d      = known_q;
    evict_d      = evict_q;
    valid_d      = valid_q;
    out_valid_d  = out_valid_q && !out_fire;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          // matching or unused entry ends the scan
          pick_d  = idx_q;
          tsel_d  = rd_time_q;
          known_d = rd_valid;
          evict_d = 1'b0;
          state_d = ST_WRITE;
        end else if (idx_q == LastIdx) begin
          // table full: replace the oldest entry
          pick_d  = take_least ? idx_q : least_idx_q;
          tsel_d  = take_least ? rd_time_q : least_time_q;
          known_d = 1'b0;
          evict_d = 1'b1;
          state_d = ST_WRITE;
        end else begin
          if (take_least) begin
            least_idx_d  = idx_q;
            least_time_d = rd_time_q;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      ST_WRITE: begin
        if (wr_fire) begin
          valid_d[pick_q] = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      interval_q  <= DefaultIntervalMs;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        interval_q <= cfg_i.reply_interval_ms;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    least_idx_q  <= least_idx_d;
    least_time_q <= least_time_d;
    pick_q       <= pick_d;
    tsel_q       <= tsel_d;
    known_q      <= known_d;
    evict_q      <= evict_d;
    if (in_fire) begin
      who_q <= req_i.requester;
      now_q <= req_i.now_ms;
    end
  end

  // Table read for the next scan index
  always_ff @(posedge clk_i) begin
    rd_req_q  <= req_mem_q[idx_d];
    rd_time_q <= time_mem_q[idx_d];
  end

  // Table write-back and result capture
  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      req_mem_q[pick_q]  <= who_q;
      time_mem_q[pick_q] <= now_q;
      out_due_q          <= due;
      out_known_q        <= known_q;
      out_evict_q        <= evict_q;
      out_index_q        <= pick_ext[EntryIndexW-1:0];
    end
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.reply_due   = out_due_q;
  assign rsp_o.was_known   = out_known_q;
  assign rsp_o.entry_index = out_index_q;
  assign rsp_o.evicted     = out_evict_q;

`ifndef SYNTHESIS
  // an accepted word always starts a scan
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_SCAN)
    else $error("accepted word did not start a scan");

  // scan only leaves early on a hit
  a_scan_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !hit && idx_q != LastIdx) |=> state_q == ST_SCAN)
    else $error("scan ended without a hit");

  // eviction never reports a known requester and is always due
  a_evict_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.evicted) |-> (!rsp_o.was_known && rsp_o.reply_due))
    else $error("evicted result inconsistent");

  // entries never become unused once written
  a_valid_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) >= $past($countones(valid_q)))
    else $error("table entry lost its valid bit");
`endif

endmodule

FILE: hw/rtl/psrt_alu.sv
// Shared unsigned compare unit: lt = (sub_en ? a - b : a) < limit
module psrt_alu (
  input  psrt_pkg::alu_req_t req_i,
  output logic               lt_o
);
  import psrt_pkg::*;

  logic [31:0] lhs;

  // Optional modular difference ahead of the compare
  always_comb begin
    if (req_i.sub_en) begin
      lhs = req_i.a - req_i.b;
    end else begin
      lhs = req_i.a;
    end
  end

  assign lt_o = (lhs < req_i.limit);

endmodule

FILE: sim/psrt_throttle_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and interval channels, keeps its own copy of the
// requester table and checks every result word against the oldest prediction.
module psrt_throttle_checker #(
  parameter int unsigned TableEntries = psrt_pkg::TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  psrt_req_if         req_i,
  psrt_rsp_if         rsp_i,
  psrt_cfg_if         cfg_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  import psrt_pkg::*;

  typedef struct packed {
    logic                   reply_due;
    logic                   was_known;
    logic [EntryIndexW-1:0] entry_index;
    logic                   evicted;
  } verdict_t;

  // Shadow table and interval
  logic        slot_used  [TableEntries];
  logic [31:0] slot_who   [TableEntries];
  logic [31:0] slot_stamp [TableEntries];
  logic [31:0] interval_ms;
  verdict_t    verdict_q[$];

  // Look up one requester, restamp the chosen slot and return the decision
  function automatic verdict_t throttle_lookup(input logic [31:0] who,
                                               input logic [31:0] now);
    verdict_t    res;
    int          pick;
    int          least;
    logic [31:0] pick_u;
    logic [31:0] elapsed;
    pick  = -1;
    least = 0;
    // first unused slot or first slot holding the requester ends the scan
    for (int k = 0; k < TableEntries; k++) begin
      if (pick < 0) begin
        if (!slot_used[k] || slot_who[k] == who) begin
          pick = k;
        end else if (slot_stamp[k] < slot_stamp[least]) begin
          least = k;
        end
      end
    end
    // full table: oldest stamp by plain compare, lowest index wins ties
    if (pick < 0) pick = least;
    pick_u          = 32'(pick);
    res.was_known   = slot_used[pick] && (slot_who[pick] == who);
    res.evicted     = slot_used[pick] && !res.was_known;
    elapsed         = now - slot_stamp[pick];
    res.reply_due   = !res.was_known || (elapsed >= interval_ms);
    res.entry_index = pick_u[EntryIndexW-1:0];
    slot_used[pick]  = 1'b1;
    slot_who[pick]   = who;
    slot_stamp[pick] = now;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_count_o++;
    end
  endfunction

  // Sample all channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      for (int k = 0; k < TableEntries; k++) begin
        slot_used[k]  = 1'b0;
        slot_who[k]   = '0;
        slot_stamp[k] = '0;
      end
      interval_ms = DefaultIntervalMs;
      verdict_q.delete();
      mismatch_count_o = 0;
    end else begin
      // result side first: a result never belongs to a word taken on the same edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result word with no request outstanding");
          mismatch_count_o++;
        end else begin
          want = verdict_q.pop_front();
          check_field("reply_due", 32'(want.reply_due), 32'(rsp_i.reply_due));
          check_field("was_known", 32'(want.was_known), 32'(rsp_i.was_known));
          check_field("entry_index", 32'(want.entry_index), 32'(rsp_i.entry_index));
          check_field("evicted", 32'(want.evicted), 32'(rsp_i.evicted));
        end
      end
      if (cfg_i.valid && cfg_i.ready) interval_ms = cfg_i.reply_interval_ms;
      if (req_i.valid && req_i.ready) begin
        verdict_q.push_back(throttle_lookup(req_i.requester, req_i.now_ms));
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

FILE: sim/per_source_reply_throttle_tb.sv
`timescale 1ns / 1ps

module per_source_reply_throttle_tb;
  import psrt_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = TableEntriesDef + 4;
  localparam int unsigned PoolSize      = 16;
  localparam int unsigned PhaseItems    = 205;
  localparam int unsigned NumPhases     = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_cycles;
  logic [31:0] who_pool [PoolSize];
  logic [31:0] phase_interval [NumPhases];
  logic [31:0] clock_ms;
  logic [31:0] last_who;
  logic [31:0] last_now;
  logic [31:0] interval_ms;

  psrt_req_if req_ch ();
  psrt_rsp_if rsp_ch ();
  psrt_cfg_if cfg_ch ();

  per_source_reply_throttle i_dut (
    .clk_i,
    .rst_ni,
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  psrt_throttle_checker i_checker (
    .clk_i,
    .rst_ni,
    .req_i            (req_ch),
    .rsp_i            (rsp_ch),
    .cfg_i            (cfg_ch),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always #4 clk_i = ~clk_i;

  // Result side back-pressure
  always @(negedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: cycles without any word moving on any channel
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one request word; returns at the falling edge after acceptance
  task automatic send_request(input logic [31:0] who, input logic [31:0] now);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.requester <= who;
    req_ch.now_ms    <= now;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
    last_who = who;
    last_now = now;
  endtask

  // Drain outstanding results, then write the interval
  task automatic write_interval(input logic [31:0] value);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.reply_interval_ms <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    interval_ms = value;
  endtask

  // Mostly pool requesters on a slowly moving clock; some exact interval
  // boundaries, fresh requesters, wild timestamps and repeated stamps
  task automatic run_phase(input int unsigned count);
    int unsigned roll;
    logic [31:0] who;
    logic [31:0] now;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      who  = who_pool[$urandom_range(0, PoolSize - 1)];
      if (roll < 45) begin
        clock_ms += $urandom_range(0, 400);
        now = clock_ms;
      end else if (roll < 65) begin
        // same requester again, one below / at / one above the interval
        who      = last_who;
        now      = last_now + interval_ms + $urandom_range(0, 2) - 32'd1;
        clock_ms = now;
      end else if (roll < 80) begin
        who = $urandom();
        clock_ms += $urandom_range(0, 400);
        now = clock_ms;
      end else if (roll < 90) begin
        now = $urandom();
      end else begin
        now = clock_ms;
      end
      send_request(who, now);
    end
  endtask

  initial begin
    req_ch.valid             = 1'b0;
    req_ch.requester         = '0;
    req_ch.now_ms            = '0;
    rsp_ch.ready             = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.reply_interval_ms = '0;
    rst_ni        = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 49;
    interval_ms   = DefaultIntervalMs;
    clock_ms      = '0;
    last_who      = '0;
    last_now      = '0;
    phase_interval = '{32'd500, 32'd0, 32'hFFFF_FFFF, 32'd1, DefaultIntervalMs,
                       32'($urandom_range(2, 2000))};
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: one day interval from reset
    send_request(32'd0, 32'd0);
    send_request(32'd0, DefaultIntervalMs - 32'd1);            // just short
    send_request(32'd0, 2 * DefaultIntervalMs - 32'd1);        // exactly one interval
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'd0);                        // timer wrap, 1 ms
    for (int k = 1; k <= 10; k++) send_request(32'(k), 32'd5); // fill the table
    send_request(32'hA5A5_A5A5, 32'd7);                        // evicts the zero stamp
    send_request(32'h5A5A_5A5A, 32'd7);                        // tie, lowest index
    send_request(32'h8000_0000, 32'h8000_0000);

    for (int p = 0; p < NumPhases; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_interval(phase_interval[p]);
      for (int i = 0; i < PoolSize; i++) who_pool[i] = $urandom();
      who_pool[0] = 32'd0;
      who_pool[1] = 32'hFFFF_FFFF;
      run_phase(PhaseItems);
    end

    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
